[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the channel and top-level RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge, switched off while rst is high
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising edge
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(label, clk, rst, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)

`endif

`endif

[hw/rtl/hsvrgb_pkg.sv]
package hsvrgb_pkg;

   // input field widths
   localparam int HUE_W = 10;
   localparam int PCT_W = 8;
   localparam int CH_W  = 8;
   // clamped percentage (0..100) and sector offset (0..60)
   localparam int PCTC_W = 7;
   localparam int OFF_W  = 6;
   // (255 - c) * pct and c * pct both stay below 2^15
   localparam int PROD_W = 15;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;

   localparam logic [HUE_W-1:0] HUE_MAX = 10'd359;
   localparam logic [PCT_W-1:0] PCT_MAX = 8'd100;
   localparam logic [CH_W-1:0]  FULL    = 8'd255;

   // lower bounds of sectors one to five, and the offset base of each
   localparam logic [HUE_W-1:0] SEC1_LO = 10'd61;
   localparam logic [HUE_W-1:0] SEC2_LO = 10'd121;
   localparam logic [HUE_W-1:0] SEC3_LO = 10'd181;
   localparam logic [HUE_W-1:0] SEC4_LO = 10'd241;
   localparam logic [HUE_W-1:0] SEC5_LO = 10'd301;
   localparam logic [HUE_W-1:0] SEC1_BASE = 10'd60;
   localparam logic [HUE_W-1:0] SEC2_BASE = 10'd120;
   localparam logic [HUE_W-1:0] SEC3_BASE = 10'd180;
   localparam logic [HUE_W-1:0] SEC4_BASE = 10'd240;
   localparam logic [HUE_W-1:0] SEC5_BASE = 10'd300;

   // x / 100 as (x * 5243) >> 19, exact for x below 43690
   localparam int DIV_PROD_W = 28;
   localparam logic [DIV_PROD_W-1:0] DIV100_RECIP = 28'd5243;
   localparam int DIV100_SHIFT = 19;

   // stage load enables for the per-channel datapath, and which of
   // stages 2 and 3 currently hold an item
   typedef struct packed {
      logic load2;
      logic load3;
      logic load4;
      logic load5;
      logic full2;
      logic full3;
   } chan_ctl_type;

   function automatic logic [CH_W-1:0] div100(input logic [PROD_W-1:0] x);
      logic [DIV_PROD_W-1:0] prod;
      logic [DIV_PROD_W-1:0] quo;
      prod = DIV_PROD_W'(x) * DIV100_RECIP;
      quo  = prod >> DIV100_SHIFT;
      return quo[CH_W-1:0];
   endfunction

endpackage

[hw/rtl/hsvrgb_hue.sv]
// Stage 1: clamp inputs, pick the hue sector and form the saturated triple
module hsvrgb_hue
   import hsvrgb_pkg::*;
(
   input  logic              clock,
   input  logic              load,
   input  logic [HUE_W-1:0]  hue,
   input  logic [PCT_W-1:0]  saturation,
   input  logic [PCT_W-1:0]  brightness,
   output logic [CH_W-1:0]   red,
   output logic [CH_W-1:0]   green,
   output logic [CH_W-1:0]   blue,
   output logic [PCTC_W-1:0] inv_sat,
   output logic [PCTC_W-1:0] bright
);

   logic [HUE_W-1:0]  hue_c;
   logic [PCT_W-1:0]  sat_c;
   logic [PCT_W-1:0]  bright_c;
   logic [HUE_W-1:0]  off_wide;
   logic [OFF_W-1:0]  off;
   logic [CH_W+1:0]   ramp_x4;
   logic [CH_W-1:0]   ramp;
   logic [CH_W-1:0]   ramp_n;
   logic [PCT_W-1:0]  inv_wide;

   logic [CH_W-1:0]   red_ff,     red_in;
   logic [CH_W-1:0]   green_ff,   green_in;
   logic [CH_W-1:0]   blue_ff,    blue_in;
   logic [PCTC_W-1:0] inv_sat_ff, inv_sat_in;
   logic [PCTC_W-1:0] bright_ff,  bright_in;

   // clamp to the meaningful ranges
   assign hue_c    = (hue > HUE_MAX) ? HUE_MAX : hue;
   assign sat_c    = (saturation > PCT_MAX) ? PCT_MAX : saturation;
   assign bright_c = (brightness > PCT_MAX) ? PCT_MAX : brightness;

   // offset into the sector
   always_comb begin
      priority if (hue_c < SEC1_LO) begin
         off_wide = hue_c;
      end else if (hue_c < SEC2_LO) begin
         off_wide = hue_c - SEC1_BASE;
      end else if (hue_c < SEC3_LO) begin
         off_wide = hue_c - SEC2_BASE;
      end else if (hue_c < SEC4_LO) begin
         off_wide = hue_c - SEC3_BASE;
      end else if (hue_c < SEC5_LO) begin
         off_wide = hue_c - SEC4_BASE;
      end else begin
         off_wide = hue_c - SEC5_BASE;
      end
   end
   assign off = off_wide[OFF_W-1:0];

   // 425 * off / 100 is exactly 17 * off / 4
   assign ramp_x4 = (CH_W+2)'({off, 4'b0000}) + (CH_W+2)'(off);
   assign ramp    = ramp_x4[CH_W+1:2];
   assign ramp_n  = FULL - ramp;

   // saturated triple per sector
   always_comb begin
      priority if (hue_c < SEC1_LO) begin
         red_in = FULL;   green_in = ramp;   blue_in = '0;
      end else if (hue_c < SEC2_LO) begin
         red_in = ramp_n; green_in = FULL;   blue_in = '0;
      end else if (hue_c < SEC3_LO) begin
         red_in = '0;     green_in = FULL;   blue_in = ramp;
      end else if (hue_c < SEC4_LO) begin
         red_in = '0;     green_in = ramp_n; blue_in = FULL;
      end else if (hue_c < SEC5_LO) begin
         red_in = ramp;   green_in = '0;     blue_in = FULL;
      end else begin
         red_in = FULL;   green_in = '0;     blue_in = ramp_n;
      end
   end

   assign inv_wide   = PCT_MAX - sat_c;
   assign inv_sat_in = inv_wide[PCTC_W-1:0];
   assign bright_in  = bright_c[PCTC_W-1:0];

   always_ff @(posedge clock) begin
      if (load) begin
         red_ff     <= red_in;
         green_ff   <= green_in;
         blue_ff    <= blue_in;
         inv_sat_ff <= inv_sat_in;
         bright_ff  <= bright_in;
      end
   end

   assign red     = red_ff;
   assign green   = green_ff;
   assign blue    = blue_ff;
   assign inv_sat = inv_sat_ff;
   assign bright  = bright_ff;

endmodule

[hw/rtl/hsvrgb_chan.sv]
`include "assert_macros.svh"

// Stages 2 to 5 for one channel: blend toward full, then scale by value
module hsvrgb_chan
   import hsvrgb_pkg::*;
(
   input  logic              clock,
   input  chan_ctl_type      ctl,
   input  logic [CH_W-1:0]   chan,
   input  logic [PCTC_W-1:0] inv_sat,
   input  logic [PCTC_W-1:0] bright,
   output logic [CH_W-1:0]   result
);

   logic [CH_W-1:0]   gap;
   logic [CH_W:0]     blend_sum;

   logic [PROD_W-1:0] prod_s2_ff, prod_s2_in;
   logic [CH_W-1:0]   chan_s2_ff;
   logic [PCTC_W-1:0] bright_s2_ff;
   logic [CH_W-1:0]   blend_s3_ff, blend_s3_in;
   logic [PCTC_W-1:0] bright_s3_ff;
   logic [PROD_W-1:0] prod_s4_ff, prod_s4_in;
   logic [CH_W-1:0]   result_ff, result_in;

   // stage 2: distance to full times (100 - s)
   assign gap        = FULL - chan;
   assign prod_s2_in = PROD_W'(gap) * PROD_W'(inv_sat);

   // stage 3: add the truncated blend share, never passes 255
   assign blend_sum   = (CH_W+1)'(chan_s2_ff) + (CH_W+1)'(div100(prod_s2_ff));
   assign blend_s3_in = blend_sum[CH_W-1:0];

   // stage 4: scale by value
   assign prod_s4_in = PROD_W'(blend_s3_ff) * PROD_W'(bright_s3_ff);

   // stage 5: truncating divide by 100
   assign result_in = div100(prod_s4_ff);

   always_ff @(posedge clock) begin
      if (ctl.load2) begin
         prod_s2_ff   <= prod_s2_in;
         chan_s2_ff   <= chan;
         bright_s2_ff <= bright;
      end
      if (ctl.load3) begin
         blend_s3_ff  <= blend_s3_in;
         bright_s3_ff <= bright_s2_ff;
      end
      if (ctl.load4) begin
         prod_s4_ff <= prod_s4_in;
      end
      if (ctl.load5) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

   // blending only ever moves a channel up toward full
   `ASSERT_CLK(a_blend_rises, clock,
      (ctl.load3 && ctl.full2) |=> blend_s3_ff >= $past(chan_s2_ff),
      "blended channel fell below its saturated value")
   // a channel already at full stays at full
   `ASSERT_CLK(a_full_stays, clock,
      (ctl.load3 && ctl.full2 && chan_s2_ff == FULL) |=> blend_s3_ff == FULL,
      "full channel moved during the blend")
   // zero value gives a zero product
   `ASSERT_CLK(a_dark_zero, clock,
      (ctl.load4 && ctl.full3 && bright_s3_ff == '0) |=> prod_s4_ff == '0,
      "zero brightness did not give a zero product")

endmodule

[hw/rtl/hsv_to_rgb_integer_unit.sv]
`include "assert_macros.svh"

// HSV to RGB converter, 8 bits per channel. Hue (degrees, clamped to 359),
// saturation and value (percent, clamped to 100) come in on the req_ stream;
// each transfer gives one red/green/blue transfer on the rsp_ stream. The
// datapath is a five-stage pipeline: sector and ramp, blend product, blend
// sum, value product, final divide. An accepted transfer moves through the
// stage registers in that order to rsp_tvalid, and with rsp_tready high a
// new item is taken every cycle. Each stage holds its item only while the
// stage after it is full and held, so a stall on the rsp_ side fills the
// bubbles first and then stops req_tready.
module hsv_to_rgb_integer_unit
   import hsvrgb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // hue [9:0], saturation [17:10], brightness [25:18], zero [31:26]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // red [7:0], green [15:8], blue [23:16]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int NSTAGE = 5;

   logic [NSTAGE-1:0] valid_ff, valid_in;
   logic [NSTAGE-1:0] ready;
   chan_ctl_type      ctl;

   logic [CH_W-1:0]   s1_red, s1_green, s1_blue;
   logic [PCTC_W-1:0] s1_inv_sat, s1_bright;
   logic [CH_W-1:0]   red, green, blue;

   // per-stage flow control: a stage loads when empty or when it drains
   always_comb begin
      ready[NSTAGE-1] = !valid_ff[NSTAGE-1] || rsp_tready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = ready[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.load2 = ready[1];
   assign ctl.load3 = ready[2];
   assign ctl.load4 = ready[3];
   assign ctl.load5 = ready[4];
   assign ctl.full2 = valid_ff[1];
   assign ctl.full3 = valid_ff[2];

   assign req_tready = ready[0];
   assign rsp_tvalid = valid_ff[NSTAGE-1];
   assign rsp_tdata  = {blue, green, red};

   hsvrgb_hue u_hue (
      .clock      (clock),
      .load       (ready[0]),
      .hue        (req_tdata[HUE_W-1:0]),
      .saturation (req_tdata[HUE_W+PCT_W-1:HUE_W]),
      .brightness (req_tdata[HUE_W+2*PCT_W-1:HUE_W+PCT_W]),
      .red        (s1_red),
      .green      (s1_green),
      .blue       (s1_blue),
      .inv_sat    (s1_inv_sat),
      .bright     (s1_bright)
   );

   hsvrgb_chan u_chan_red (
      .clock   (clock),
      .ctl     (ctl),
      .chan    (s1_red),
      .inv_sat (s1_inv_sat),
      .bright  (s1_bright),
      .result  (red)
   );

   hsvrgb_chan u_chan_green (
      .clock   (clock),
      .ctl     (ctl),
      .chan    (s1_green),
      .inv_sat (s1_inv_sat),
      .bright  (s1_bright),
      .result  (green)
   );

   hsvrgb_chan u_chan_blue (
      .clock   (clock),
      .ctl     (ctl),
      .chan    (s1_blue),
      .inv_sat (s1_inv_sat),
      .bright  (s1_bright),
      .result  (blue)
   );

   // input side only backs up when the first stage is holding an item
   `ASSERT_RST(a_stall_needs_item, clock, reset,
      !req_tready |-> valid_ff[0],
      "req_tready low with the first stage empty")
   // reset empties the whole pipeline
   `ASSERT_CLK(a_reset_empties, clock,
      $past(reset) |-> valid_ff == '0,
      "pipeline not empty after reset")
   // every saturated triple has at least one channel at full
   `ASSERT_RST(a_one_full, clock, reset,
      valid_ff[0] |-> (s1_red == FULL || s1_green == FULL || s1_blue == FULL),
      "saturated triple without a full channel")

endmodule
